// ===== src/overload_level_controller_core_macros.svh =====
// Assertion macros shared by the overload level controller RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef OVERLOAD_LEVEL_CONTROLLER_CORE_MACROS_SVH
`define OVERLOAD_LEVEL_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication.
`define OLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/olc_pkg.sv =====
// Package for the overload level controller: level, request and register codes,
// configuration, pipeline item and result types. No dependencies.
package olc_pkg;

  localparam int TH_W       = 14;
  localparam int CONN_W     = 16;
  localparam int PROD_W     = 30;
  localparam int WAIT_W     = 16;
  localparam int WAIT_MS_W  = 26;
  localparam int CFG_DATA_W = 56;
  localparam int CFG_IDX_W  = 3;

  localparam logic [29:0] CONN_SCALE = 30'd10000;
  localparam logic [25:0] MS_PER_S   = 26'd1000;

  localparam logic [55:0] TH4_RESET   = 56'd43983149629450000;
  localparam logic [41:0] TH3_RESET   = 42'd2684518410000;
  localparam logic [1:0]  MODES_RESET = 2'd3;

  typedef enum logic [2:0] {
    LVL_NORMAL   = 3'd0,
    LVL_LIGHT    = 3'd1,
    LVL_MODERATE = 3'd2,
    LVL_SEVERE   = 3'd3,
    LVL_CRITICAL = 3'd4
  } level_t;

  typedef enum logic [1:0] {
    REQ_METRICS = 2'd0,
    REQ_FORCE   = 2'd1,
    REQ_QUERY   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_TH   = 3'd0,
    CFG_MEM_TH   = 3'd1,
    CFG_CONN_TH  = 3'd2,
    CFG_MARGIN   = 3'd3,
    CFG_ESC_WAIT = 3'd4,
    CFG_REC_WAIT = 3'd5,
    CFG_MODES    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0][TH_W-1:0] cpu_th;
    logic [3:0][TH_W-1:0] mem_th;
    logic [2:0][TH_W-1:0] conn_th;
    logic [TH_W-1:0]      margin;
    logic [WAIT_W-1:0]    esc_wait;
    logic [WAIT_W-1:0]    rec_wait;
    logic [1:0]           auto_modes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [31:0]            now_ms;
    logic [TH_W-1:0]        cpu_load;
    logic [TH_W-1:0]        mem_load;
    logic                   conn_en;
    logic [PROD_W-1:0]      conn_scaled;
    logic [2:0][PROD_W-1:0] conn_prod;
    logic [2:0]             forced_level;
    logic                   critical_op;
  } item_t;

  typedef struct packed {
    logic [2:0]  level_now;
    logic        level_changed;
    logic [2:0]  level_before;
    logic        entered_degraded;
    logic        entered_normal;
    logic        reject_pulse;
    logic        op_allowed;
    logic        accept_new;
    logic        drop_low;
    logic [4:0]  ack_batch;
    logic [31:0] change_total;
    logic [31:0] throttle_total;
  } rsp_t;

endpackage

// ===== src/olc_cfg_regs.sv =====
// Configuration register file for the overload level controller.
// Depends on olc_pkg.
module olc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [olc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [olc_pkg::CFG_DATA_W-1:0] cfg_data,
  output olc_pkg::cfg_t                  cfg
);
  import olc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cpu_th     <= TH4_RESET;
      cfg.mem_th     <= TH4_RESET;
      cfg.conn_th    <= TH3_RESET;
      cfg.margin     <= '0;
      cfg.esc_wait   <= '0;
      cfg.rec_wait   <= '0;
      cfg.auto_modes <= MODES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CPU_TH:   cfg.cpu_th     <= cfg_data;
        CFG_MEM_TH:   cfg.mem_th     <= cfg_data;
        CFG_CONN_TH:  cfg.conn_th    <= cfg_data[41:0];
        CFG_MARGIN:   cfg.margin     <= cfg_data[TH_W-1:0];
        CFG_ESC_WAIT: cfg.esc_wait   <= cfg_data[WAIT_W-1:0];
        CFG_REC_WAIT: cfg.rec_wait   <= cfg_data[WAIT_W-1:0];
        CFG_MODES:    cfg.auto_modes <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/olc_input_stage.sv =====
// Input register of the overload level controller; also registers the
// connection share products. Depends on olc_pkg.
module olc_input_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  olc_pkg::cfg_t               cfg,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [31:0]                 now_ms,
  input  logic [olc_pkg::TH_W-1:0]    cpu_load,
  input  logic [olc_pkg::TH_W-1:0]    mem_load,
  input  logic [olc_pkg::CONN_W-1:0]  conns_active,
  input  logic [olc_pkg::CONN_W-1:0]  conns_max,
  input  logic [2:0]                  forced_level,
  input  logic                        critical_op,
  input  logic                        advance,
  output logic                        item_valid,
  output olc_pkg::item_t              item
);
  import olc_pkg::*;

  logic  accept;
  item_t item_next;

  assign req_stall = item_valid && !advance;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    item_next.req_type     = req_type;
    item_next.now_ms       = now_ms;
    item_next.cpu_load     = cpu_load;
    item_next.mem_load     = mem_load;
    item_next.conn_en      = (conns_max != '0);
    item_next.conn_scaled  = PROD_W'(conns_active) * CONN_SCALE;
    for (int k = 0; k < 3; k++) begin
      item_next.conn_prod[k] = PROD_W'(cfg.conn_th[k]) * PROD_W'(conns_max);
    end
    item_next.forced_level = forced_level;
    item_next.critical_op  = critical_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

// ===== src/olc_level_core.sv =====
// Level decision, controller state and result register of the overload
// level controller. Depends on olc_pkg and the assertion macro header.
module olc_level_core (
  input  logic           clk,
  input  logic           rst,
  input  olc_pkg::cfg_t  cfg,
  input  olc_pkg::item_t item,
  input  logic           load,
  input  logic           rsp_stall,
  output logic           rsp_valid,
  output olc_pkg::rsp_t  rsp
);
  import olc_pkg::*;
  `include "overload_level_controller_core_macros.svh"

  level_t                cur_level;
  level_t                level_next;
  logic [31:0]           changed_at_ms;
  logic [31:0]           changes_count;
  logic [31:0]           changes_count_next;
  logic [31:0]           throttled_count;
  logic [31:0]           throttled_count_next;

  logic                  cpu_hit, mem_hit, conn_hit;
  level_t                cpu_tgt, mem_tgt, conn_tgt, target;
  logic [31:0]           elapsed_ms;
  logic [WAIT_MS_W-1:0]  esc_ms, rec_ms;
  logic                  esc_ok, rec_time_ok, rec_ok;
  logic [1:0]            slot;
  logic                  move, changed, throttle;
  level_t                move_lvl;

  assign elapsed_ms  = item.now_ms - changed_at_ms;
  assign esc_ms      = WAIT_MS_W'(cfg.esc_wait) * MS_PER_S;
  assign rec_ms      = WAIT_MS_W'(cfg.rec_wait) * MS_PER_S;
  assign esc_ok      = elapsed_ms >= 32'(esc_ms);
  assign rec_time_ok = elapsed_ms >= 32'(rec_ms);
  assign slot        = 2'(cur_level - 3'd1);
  assign rec_ok      = ((TH_W+1)'(item.cpu_load) + (TH_W+1)'(cfg.margin)
                        < (TH_W+1)'(cfg.cpu_th[slot]))
                    && ((TH_W+1)'(item.mem_load) + (TH_W+1)'(cfg.margin)
                        < (TH_W+1)'(cfg.mem_th[slot]));

  always_comb begin
    cpu_hit  = 1'b0;
    mem_hit  = 1'b0;
    conn_hit = 1'b0;
    cpu_tgt  = LVL_NORMAL;
    mem_tgt  = LVL_NORMAL;
    conn_tgt = LVL_NORMAL;
    for (int k = 0; k < 4; k++) begin
      if (item.cpu_load >= cfg.cpu_th[k]) begin
        cpu_hit = 1'b1;
        cpu_tgt = level_t'(3'(k + 1));
      end
      if (item.mem_load >= cfg.mem_th[k]) begin
        mem_hit = 1'b1;
        mem_tgt = level_t'(3'(k + 1));
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (item.conn_en && (item.conn_scaled >= item.conn_prod[k])) begin
        conn_hit = 1'b1;
        conn_tgt = level_t'(3'(k + 2));
      end
    end
    if (cpu_hit) begin
      target = cpu_tgt;
    end else if (mem_hit) begin
      target = mem_tgt;
    end else if (conn_hit) begin
      target = conn_tgt;
    end else begin
      target = LVL_NORMAL;
    end
  end

  always_comb begin
    move     = 1'b0;
    move_lvl = cur_level;
    throttle = 1'b0;
    unique case (item.req_type)
      REQ_METRICS: begin
        if ((target > cur_level) && cfg.auto_modes[0] && esc_ok) begin
          move     = 1'b1;
          move_lvl = target;
        end else if ((target < cur_level) && cfg.auto_modes[1] && rec_time_ok && rec_ok) begin
          move     = 1'b1;
          move_lvl = target;
        end
      end
      REQ_FORCE: begin
        move     = 1'b1;
        move_lvl = (item.forced_level > 3'(LVL_CRITICAL)) ? LVL_CRITICAL
                                                          : level_t'(item.forced_level);
      end
      REQ_QUERY: begin
        throttle = !item.critical_op && (cur_level >= LVL_MODERATE);
      end
      default: ;
    endcase
    changed              = move && (move_lvl != cur_level);
    level_next           = changed ? move_lvl : cur_level;
    changes_count_next   = changes_count + 32'(changed);
    throttled_count_next = throttled_count + 32'(throttle);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level       <= LVL_NORMAL;
      changed_at_ms   <= '0;
      changes_count   <= '0;
      throttled_count <= '0;
    end else if (load) begin
      cur_level       <= level_next;
      changes_count   <= changes_count_next;
      throttled_count <= throttled_count_next;
      if (changed) begin
        changed_at_ms <= item.now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.level_now        <= level_next;
      rsp.level_changed    <= changed;
      rsp.level_before     <= cur_level;
      rsp.entered_degraded <= changed && (cur_level == LVL_NORMAL);
      rsp.entered_normal   <= changed && (move_lvl == LVL_NORMAL);
      rsp.reject_pulse     <= changed && (move_lvl >= LVL_SEVERE);
      rsp.op_allowed       <= !throttle;
      rsp.accept_new       <= level_next <= LVL_MODERATE;
      rsp.drop_low         <= level_next >= LVL_MODERATE;
      rsp.ack_batch        <= 5'd1 << level_next;
      rsp.change_total     <= changes_count_next;
      rsp.throttle_total   <= throttled_count_next;
    end
  end

  `OLC_ASSERT_IMP(a_level_range, 1'b1, cur_level <= LVL_CRITICAL, "level out of range")
  `OLC_ASSERT_NEXT(a_change_counted, load && changed, changes_count == $past(changes_count) + 32'd1, "level change not counted")
  `OLC_ASSERT_NEXT(a_level_held, load && !changed, cur_level == $past(cur_level), "level moved without a change")
  `OLC_ASSERT_IMP(a_normal_pulse, rsp_valid && rsp.entered_normal, rsp.level_now == LVL_NORMAL, "entered normal with a degraded level")

endmodule

// ===== src/overload_level_controller_core.sv =====
// Overload level controller, top level.
// Request channel (req_valid, req_stall): a transfer takes place when req_valid is
// high and req_stall is low. Response channel (rsp_valid, rsp_stall) works the same
// way, with rsp_stall driven by the receiver.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes one
// register per transfer; cfg_ready is always high. Unknown indexes are ignored.
// Each request passes the input register, then the response register, to become a response.
// Throughput is one item per cycle while the receiver does not stall: the input register
// and the response register form a two-stage pipeline, and the level state is updated
// as an item moves into the response register, so the next item sees the new state.
// While the receiver stalls, the response holds, and the input register fills and
// then stalls the sender. Reset clears the level to normal, the change timestamp
// and both counters, and loads the register defaults.
// Depends on olc_pkg, olc_cfg_regs, olc_input_stage and olc_level_core.
module overload_level_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [olc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [olc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [1:0]                     req_type,
  input  logic [31:0]                    now_ms,
  input  logic [olc_pkg::TH_W-1:0]       cpu_load,
  input  logic [olc_pkg::TH_W-1:0]       mem_load,
  input  logic [olc_pkg::CONN_W-1:0]     conns_active,
  input  logic [olc_pkg::CONN_W-1:0]     conns_max,
  input  logic [2:0]                     forced_level,
  input  logic                           critical_op,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [2:0]                     level_now,
  output logic                           level_changed,
  output logic [2:0]                     level_before,
  output logic                           entered_degraded,
  output logic                           entered_normal,
  output logic                           reject_pulse,
  output logic                           op_allowed,
  output logic                           accept_new,
  output logic                           drop_low,
  output logic [4:0]                     ack_batch,
  output logic [31:0]                    change_total,
  output logic [31:0]                    throttle_total
);
  import olc_pkg::*;

  cfg_t  cfg;
  item_t item;
  rsp_t  rsp;
  logic  item_valid;
  logic  load;

  assign load = item_valid && (!rsp_valid || !rsp_stall);

  olc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  olc_input_stage u_input (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .now_ms       (now_ms),
    .cpu_load     (cpu_load),
    .mem_load     (mem_load),
    .conns_active (conns_active),
    .conns_max    (conns_max),
    .forced_level (forced_level),
    .critical_op  (critical_op),
    .advance      (load),
    .item_valid   (item_valid),
    .item         (item)
  );

  olc_level_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .load      (load),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  assign level_now        = rsp.level_now;
  assign level_changed    = rsp.level_changed;
  assign level_before     = rsp.level_before;
  assign entered_degraded = rsp.entered_degraded;
  assign entered_normal   = rsp.entered_normal;
  assign reject_pulse     = rsp.reject_pulse;
  assign op_allowed       = rsp.op_allowed;
  assign accept_new       = rsp.accept_new;
  assign drop_low         = rsp.drop_low;
  assign ack_batch        = rsp.ack_batch;
  assign change_total     = rsp.change_total;
  assign throttle_total   = rsp.throttle_total;

endmodule
